// ===== sv/ntc_temperature_conditioner_top_assert.svh =====
// assertion macros for the ntc conditioner
`ifndef NTC_TEMPERATURE_CONDITIONER_TOP_ASSERT_SVH
`define NTC_TEMPERATURE_CONDITIONER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NTC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define NTC_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define NTC_ASSERT_IMP(label, clk, rst_n, a, c)
`define NTC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/ntc_pkg.sv =====
// shared types and constants for the ntc conditioner
package ntc_pkg;
    // samples per averaged reading
    localparam int SAMPLES = 8;

    localparam logic [1:0] CH_HEATER  = 2'd0;
    localparam logic [1:0] CH_CHAMBER = 2'd1;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;
    localparam logic [1:0] REG_RISE  = 2'd0;
    localparam logic [1:0] REG_FALL  = 2'd1;
    localparam logic [1:0] REG_STEPS = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [1:0] channel;
        logic [9:0] adc_code;
        logic [9:0] table_index;
        logic [7:0] table_whole;
        logic [7:0] table_tenths;
        logic       target_arrived;
        logic       cooling;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_channel;
        logic [9:0]  average_code;
        logic [7:0]  whole_degrees;
        logic [7:0]  tenths;
        logic [11:0] temperature_x10;
    } out_item_t;

    // averaged work item passed from front to back
    typedef struct packed {
        logic [1:0] channel;
        logic [9:0] average_code;
        logic       target_arrived;
        logic       cooling;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_READ, BK_CALC, BK_MUL, BK_DIV, BK_CONV, BK_OUT
    } back_state_t;
endpackage

// ===== sv/ntc_ram.sv =====
// generic ram with one write port and one registered read port
module ntc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/ntc_front.sv =====
// front end: sample accumulation and table writes
module ntc_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  ntc_pkg::in_item_t              in_data,
    output logic                           q_push,
    output ntc_pkg::job_t                  q_data,
    input  logic                           q_full,
    input  logic                           hold_writes,
    output logic                           tw_heater,
    output logic                           tw_chamber,
    output logic [$clog2(TABLE_DEPTH)-1:0] tw_addr,
    output logic [15:0]                    tw_data
);
    import ntc_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0] sum_reg, sum_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        acc, wr_ok, done;
    logic [15:0] avg_full;

    // table writes wait while a reading is queued or in the back end
    assign in_stall = q_full || (in_data.operation == OP_WRITE && hold_writes);
    assign acc = in_valid && !in_stall;
    assign wr_ok = acc && in_data.operation == OP_WRITE
                   && {6'd0, in_data.table_index} < 16'(TABLE_DEPTH);
    assign tw_heater  = wr_ok && in_data.channel == CH_HEATER;
    assign tw_chamber = wr_ok && in_data.channel != CH_HEATER;
    assign tw_addr = in_data.table_index[AW-1:0];
    assign tw_data = {in_data.table_whole, in_data.table_tenths};

    // accumulate a run of samples
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        done = 1'b0;
        if (acc && in_data.operation == OP_SAMPLE)
        begin
            sum_next = sum_reg + {6'd0, in_data.adc_code};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_next == 7'(SAMPLES))
            begin
                done = 1'b1;
            end
        end
    end

    assign avg_full = sum_next / 16'(SAMPLES);
    assign q_push = done;
    assign q_data = '{channel: in_data.channel, average_code: avg_full[9:0],
                      target_arrived: in_data.target_arrived,
                      cooling: in_data.cooling};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (done)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== sv/ntc_queue.sv =====
// two entry job queue between front and back
module ntc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ntc_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output ntc_pkg::job_t pop_data
);
    import ntc_pkg::*;
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== sv/ntc_back.sv =====
// back end: table lookup, chamber filter and result register
module ntc_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  ntc_pkg::job_t                  job,
    output logic                           job_pop,
    output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic [15:0]                    heater_rd,
    input  logic [15:0]                    chamber_rd,
    input  logic [8:0]                     smooth_rise,
    input  logic [8:0]                     smooth_fall,
    input  logic [15:0]                    blend_steps,
    output logic                           out_valid,
    input  logic                           out_stall,
    output ntc_pkg::out_item_t             out_data,
    output logic                           busy
);
    import ntc_pkg::*;
    localparam int AW = $clog2(TABLE_DEPTH);

    back_state_t st_reg, st_next;
    job_t        job_reg;
    logic [7:0]  whole_reg, tenth_reg;
    logic [11:0] t10_reg;
    logic [19:0] last_reg;
    logic [15:0] ramp_reg;
    logic [39:0] acc_reg;      // dividend, then quotient bits shifted in
    logic [15:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [19:0] fresh_reg;
    logic [1:0]  mph_reg;
    logic        ov_reg;
    out_item_t   od_reg;
    logic [15:0] entry;
    logic [8:0]  c;
    logic [16:0] trial;
    logic [11:0] t10s;
    logic [27:0] prod;
    logic [8:0]  wq;
    logic [3:0]  tq;

    // table address of the job being worked on
    assign rd_addr = (job_reg.average_code > 10'(TABLE_DEPTH - 1)) ?
                     AW'(TABLE_DEPTH - 1) : job_reg.average_code[AW-1:0];
    assign entry = (job_reg.channel == CH_HEATER) ? heater_rd : chamber_rd;
    assign c = job_reg.cooling ? (smooth_fall > 9'd256 ? 9'd256 : smooth_fall)
                               : (smooth_rise > 9'd256 ? 9'd256 : smooth_rise);
    assign trial = {rem_reg, acc_reg[39]} - {1'b0, blend_steps};
    assign t10s = acc_reg[19:8];
    // divide by ten through a reciprocal multiply
    assign prod = {16'd0, t10s} * 28'd6554;
    assign wq = prod[24:16];
    assign tq = 4'(t10s - {3'd0, wq} * 12'd10);

    assign job_pop = st_reg == BK_IDLE && job_valid;
    assign busy = st_reg != BK_IDLE || ov_reg;
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // sequencer next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE: if (job_valid) st_next = BK_READ;
            BK_READ: st_next = BK_CALC;
            BK_CALC:
            begin
                if (job_reg.channel != CH_CHAMBER) st_next = BK_OUT;
                else if (!job_reg.target_arrived) st_next = BK_MUL;
                else if (ramp_reg < blend_steps) st_next = BK_MUL;
                else st_next = BK_CONV;
            end
            BK_MUL: if (mph_reg == 2'd1 || !job_reg.target_arrived) st_next =
                        job_reg.target_arrived ? BK_DIV : BK_CONV;
            BK_DIV: if (bit_reg == 6'd39) st_next = BK_CONV;
            BK_CONV: st_next = BK_OUT;
            BK_OUT: if (!ov_reg || !out_stall) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (st_reg)
            BK_IDLE: if (job_valid) job_reg <= job;
            BK_CALC:
            begin
                whole_reg <= entry[15:8];
                tenth_reg <= entry[7:0];
                t10_reg <= 12'({4'd0, entry[15:8]} * 12'd10 + {4'd0, entry[7:0]});
                fresh_reg <= {12'({4'd0, entry[15:8]} * 12'd10 + {4'd0, entry[7:0]}),
                              8'd0};
                mph_reg <= 2'd0;
                bit_reg <= '0;
                rem_reg <= '0;
                acc_reg <= {20'd0, 12'({4'd0, entry[15:8]} * 12'd10
                            + {4'd0, entry[7:0]}), 8'd0};
            end
            BK_MUL:
            begin
                if (!job_reg.target_arrived)
                begin
                    acc_reg <= {8'd0, 32'((29'(c) * 29'(fresh_reg)
                               + 29'(9'd256 - c) * 29'(last_reg) + 29'd128) >> 8)};
                end
                else if (mph_reg == 2'd0)
                begin
                    acc_reg <= 40'(36'(ramp_reg) * 36'(fresh_reg));
                    mph_reg <= 2'd1;
                end
                else
                begin
                    acc_reg <= acc_reg + 40'(36'(blend_steps - ramp_reg) * 36'(last_reg))
                               + 40'(blend_steps >> 1);
                end
            end
            BK_DIV:
            begin
                bit_reg <= bit_reg + 6'd1;
                if (!trial[16])
                begin
                    rem_reg <= trial[15:0];
                    acc_reg <= {acc_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[14:0], acc_reg[39]};
                    acc_reg <= {acc_reg[38:0], 1'b0};
                end
            end
            BK_CONV:
            begin
                t10_reg <= t10s;
                whole_reg <= (wq > 9'd255) ? 8'd255 : wq[7:0];
                tenth_reg <= {4'd0, tq};
            end
            default: ;
        endcase
    end

    // filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            ramp_reg <= '0;
            ov_reg <= 1'b0;
            od_reg <= '0;
        end
        else
        begin
            if (st_reg == BK_MUL && !job_reg.target_arrived)
            begin
                last_reg <= 20'(32'((29'(c) * 29'(fresh_reg)
                            + 29'(9'd256 - c) * 29'(last_reg) + 29'd128) >> 8));
                ramp_reg <= '0;
            end
            // step the crossfade once both weights have been used
            if (st_reg == BK_MUL && job_reg.target_arrived && mph_reg == 2'd1)
            begin
                ramp_reg <= ramp_reg + 16'd1;
            end
            if (st_reg == BK_OUT && (!ov_reg || !out_stall))
            begin
                ov_reg <= 1'b1;
                od_reg <= '{result_channel: job_reg.channel,
                            average_code: job_reg.average_code,
                            whole_degrees: whole_reg, tenths: tenth_reg,
                            temperature_x10: t10_reg};
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/ntc_temperature_conditioner_top.sv =====
// top level of the ntc temperature conditioner
// NTC conditioner: input items are taken at up to one per cycle, unless stalled,
// into a sample accumulator; every SAMPLES samples one averaged job enters a two
// entry queue. After queue pop the back end reads the table; non-chamber jobs go
// to the result register, chamber jobs via a conversion state, smoothed ones
// first via a filter multiply, crossfades via two multiply phases and a 40 step
// restoring divider. Table writes are held off while a reading is queued or in
// the back end, so each lookup sees the table as it stood when its last sample
// came in. Tables start undefined and must be loaded before they are read.
module ntc_temperature_conditioner_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ntc_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ntc_pkg::out_item_t   out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import ntc_pkg::*;
    `include "ntc_temperature_conditioner_top_assert.svh"
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [8:0]  rise_reg, fall_reg;
    logic [15:0] steps_reg;
    logic        q_push, q_full, q_pop, q_ne, busy, twh, twc;
    job_t        q_in, q_out;
    logic [AW-1:0] tw_addr, rd_addr;
    logic [15:0] tw_data, hrd, crd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg <= 9'd128;
            fall_reg <= 9'd128;
            steps_reg <= 16'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RISE: rise_reg <= cfg_data[8:0];
                REG_FALL: fall_reg <= cfg_data[8:0];
                REG_STEPS: steps_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ntc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .q_push(q_push), .q_data(q_in), .q_full(q_full),
        .hold_writes(q_ne || busy),
        .tw_heater(twh), .tw_chamber(twc), .tw_addr(tw_addr), .tw_data(tw_data));

    ntc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_data(q_out));

    ntc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_heater_ram (
        .clk(clk), .we(twh), .waddr(tw_addr), .wdata(tw_data),
        .raddr(rd_addr), .rdata(hrd));

    ntc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_chamber_ram (
        .clk(clk), .we(twc), .waddr(tw_addr), .wdata(tw_data),
        .raddr(rd_addr), .rdata(crd));

    ntc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_ne), .job(q_out), .job_pop(q_pop),
        .rd_addr(rd_addr), .heater_rd(hrd), .chamber_rd(crd),
        .smooth_rise(rise_reg), .smooth_fall(fall_reg), .blend_steps(steps_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .busy(busy));

    `NTC_ASSERT_IMP(a_no_push_full, clk, rst_n, q_full, !q_push)
    `NTC_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, q_ne)
    `NTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule
